[hdl/stepper_phase_sequencer_assert.svh]
// assertion macros shared by the sequencer rtl
// each check samples on clk_i and is disabled while rst_ni is low
`ifndef STEPPER_PHASE_SEQUENCER_ASSERT_SVH
`define STEPPER_PHASE_SEQUENCER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define SPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sps assertion failed");

// next-cycle implication
`define SPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sps assertion failed");

`else

`define SPS_ASSERT_NOW(lbl, ante, cons)
`define SPS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hdl/sps_pkg.sv]
package sps_pkg;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // step modes
  localparam logic [1:0] MODE_WAVE  = 2'd0;
  localparam logic [1:0] MODE_FULL  = 2'd1;
  localparam logic [1:0] MODE_HALF  = 2'd2;
  localparam logic [1:0] MODE_MICRO = 2'd3;

  // register indexes
  localparam logic [1:0] REG_STEP_MODE     = 2'd0;
  localparam logic [1:0] REG_CLOCKWISE     = 2'd1;
  localparam logic [1:0] REG_STEP_INTERVAL = 2'd2;

  localparam int unsigned PWM_PERIOD = 1000;
  localparam int unsigned MAX_STEPS  = 65535;

  localparam logic [23:0] INTERVAL_RESET = 24'd10000;

  typedef struct packed {
    logic [1:0]  step_mode;
    logic        clockwise;
    logic [23:0] step_interval;
  } cfg_t;

  typedef struct packed {
    logic [3:0] coils;
    logic       moving;
    logic       step_strobe;
  } res_t;

  // micro-step duty table, 0..1000
  function automatic logic [9:0] duty_lookup(input logic [4:0] idx);
    logic [9:0] d;
    unique case (idx)
      5'd0:  d = 10'd500;
      5'd1:  d = 10'd625;
      5'd2:  d = 10'd750;
      5'd3:  d = 10'd875;
      5'd4:  d = 10'd1000;
      5'd5:  d = 10'd875;
      5'd6:  d = 10'd750;
      5'd7:  d = 10'd625;
      5'd8:  d = 10'd500;
      5'd9:  d = 10'd375;
      5'd10: d = 10'd250;
      5'd11: d = 10'd125;
      5'd29: d = 10'd125;
      5'd30: d = 10'd250;
      5'd31: d = 10'd375;
      default: d = 10'd0;
    endcase
    return d;
  endfunction

  // coil levels for wave, full and half modes; bit0 is coil a
  function automatic logic [3:0] pattern_levels(input logic [1:0] mode,
                                                input logic       cw,
                                                input logic [4:0] phase);
    logic [3:0] lv;
    logic [2:0] off [4];
    logic [2:0] pos;
    lv = '0;
    unique case (mode)
      MODE_WAVE: begin
        off[0] = 3'd0;
        off[1] = 3'd2;
        off[2] = cw ? 3'd3 : 3'd1;
        off[3] = cw ? 3'd1 : 3'd3;
      end
      MODE_FULL: begin
        off[0] = cw ? 3'd1 : 3'd0;
        off[1] = cw ? 3'd3 : 3'd2;
        off[2] = cw ? 3'd0 : 3'd1;
        off[3] = cw ? 3'd2 : 3'd3;
      end
      default: begin
        off[0] = 3'd0;
        off[1] = 3'd4;
        off[2] = 3'd2;
        off[3] = 3'd6;
      end
    endcase
    for (int k = 0; k < 4; k++) begin
      pos = off[k] + phase[2:0];
      unique case (mode)
        MODE_WAVE: lv[k] = (pos[1:0] == 2'd0);
        MODE_FULL: lv[k] = (pos[1:0] < 2'd2);
        default:   lv[k] = (pos < 3'd3);
      endcase
    end
    return lv;
  endfunction

endpackage

[hdl/sps_engine.sv]
`include "stepper_phase_sequencer_assert.svh"

module sps_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [1:0]        command_i,
  input  logic [15:0]       step_count_i,
  input  sps_pkg::cfg_t     cfg_i,
  output sps_pkg::res_t     res_o
);

  logic [4:0]  phase_q, phase_d;
  logic [15:0] steps_q, steps_d;
  logic [23:0] ivl_cnt_q, ivl_cnt_d;
  logic [9:0]  pwm_q, pwm_d;
  logic        busy_q, busy_d;
  logic [3:0]  coil_q, coil_d;

  logic [23:0] ivl;
  logic [23:0] ivl_inc;
  logic [15:0] cnt_sat;
  logic [4:0]  phase_adv;
  logic [9:0]  pwm_cur;
  logic [10:0] pwm_inc;
  logic [3:0]  micro_lv;
  logic        strobe;
  logic        is_micro;
  logic [4:0]  idx [4];

  assign is_micro = (cfg_i.step_mode == sps_pkg::MODE_MICRO);
  assign ivl      = (cfg_i.step_interval == '0) ? 24'd1 : cfg_i.step_interval;
  assign ivl_inc  = ivl_cnt_q + 24'd1;
  assign cnt_sat  = (32'(step_count_i) > sps_pkg::MAX_STEPS) ?
                    16'(sps_pkg::MAX_STEPS) : step_count_i;
  // half and micro run backwards when clockwise
  assign phase_adv = (cfg_i.step_mode[1] && cfg_i.clockwise) ? phase_q - 5'd1
                                                              : phase_q + 5'd1;

  // state update for one item
  always_comb begin
    phase_d   = phase_q;
    steps_d   = steps_q;
    ivl_cnt_d = ivl_cnt_q;
    busy_d    = busy_q;
    coil_d    = coil_q;
    strobe    = 1'b0;
    pwm_cur   = pwm_q;
    unique case (command_i)
      sps_pkg::CMD_START: begin
        phase_d   = '0;
        ivl_cnt_d = '0;
        pwm_cur   = '0;
        if (cnt_sat == '0) begin
          busy_d  = 1'b0;
          steps_d = '0;
        end else begin
          busy_d  = 1'b1;
          steps_d = cnt_sat - 16'd1;
          coil_d  = is_micro ? 4'b0 :
                    sps_pkg::pattern_levels(cfg_i.step_mode, cfg_i.clockwise, 5'd0);
          strobe  = 1'b1;
        end
      end
      sps_pkg::CMD_STOP: begin
        if (busy_q) begin
          busy_d    = 1'b0;
          steps_d   = '0;
          ivl_cnt_d = '0;
          if (is_micro) coil_d = '0;
        end
      end
      sps_pkg::CMD_TICK: begin
        if (busy_q) begin
          if (ivl_inc >= ivl) begin
            ivl_cnt_d = '0;
            if (steps_q != '0) begin
              steps_d = steps_q - 16'd1;
              phase_d = phase_adv;
              coil_d  = is_micro ? 4'b0 :
                        sps_pkg::pattern_levels(cfg_i.step_mode, cfg_i.clockwise,
                                                phase_adv);
              strobe  = 1'b1;
            end else begin
              busy_d = 1'b0;
              steps_d = '0;
              if (is_micro) coil_d = '0;
            end
          end else begin
            ivl_cnt_d = ivl_inc;
          end
        end
      end
      default: ;
    endcase
  end

  // four pwm channels compared at once, per-coil table offsets
  assign idx[0] = phase_d;
  assign idx[1] = phase_d + 5'd16;
  assign idx[2] = phase_d + 5'd8;
  assign idx[3] = phase_d + 5'd24;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      micro_lv[k] = (pwm_cur < sps_pkg::duty_lookup(idx[k]));
    end
  end

  // pwm counter advances on ticks after the output is formed
  assign pwm_inc = {1'b0, pwm_q} + 11'd1;
  always_comb begin
    pwm_d = pwm_cur;
    if (command_i == sps_pkg::CMD_TICK) begin
      pwm_d = (32'(pwm_inc) >= sps_pkg::PWM_PERIOD) ? 10'd0 : pwm_inc[9:0];
    end
  end

  assign res_o.coils       = (busy_d && is_micro) ? micro_lv : coil_d;
  assign res_o.moving      = busy_d;
  assign res_o.step_strobe = strobe;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      steps_q   <= '0;
      ivl_cnt_q <= '0;
      pwm_q     <= '0;
      busy_q    <= 1'b0;
      coil_q    <= '0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      steps_q   <= steps_d;
      ivl_cnt_q <= ivl_cnt_d;
      pwm_q     <= pwm_d;
      busy_q    <= busy_d;
      coil_q    <= coil_d;
    end
  end

  `SPS_ASSERT_NOW(a_steps_only_busy, steps_q != '0, busy_q)
  `SPS_ASSERT_NOW(a_ivl_only_busy, ivl_cnt_q != '0, busy_q)
  `SPS_ASSERT_NOW(a_pwm_in_period, 1'b1, pwm_q < 10'(sps_pkg::PWM_PERIOD))

endmodule

[hdl/stepper_phase_sequencer.sv]
// channel | direction | transfer when
// --------+-----------+---------------------------------------------
// in      | to block  | in_valid_i high and in_stall_o low at clk_i
// out     | from block| out_valid_o high and out_stall_i low at clk_i
// apb     | to block  | psel, penable, pwrite (pready tied high)
//
// one item per clock sustained while the output does not stall; each input transfer
// goes through the input register, then step logic into the result register
// rst_ni clears the timers, phase, move state and coils; registers reload
// their defaults (full step, clockwise, 10000 ticks)
// a stall on a full result register holds both stages; in_stall_o rises only when the
// input register is full and cannot move on
`include "stepper_phase_sequencer_assert.svh"

module stepper_phase_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] step_count_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        coil_a_o,
  output logic        coil_b_o,
  output logic        coil_c_o,
  output logic        coil_d_o,
  output logic        moving_o,
  output logic        step_strobe_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sps_pkg::cfg_t cfg_q;
  logic          cfg_wr;
  logic [1:0]    reg_idx;

  logic          s1_valid_q;
  logic [1:0]    s1_cmd_q;
  logic [15:0]   s1_cnt_q;
  logic          advance;

  sps_pkg::res_t res_d, res_q;
  logic          out_valid_q;

  // register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_mode     <= sps_pkg::MODE_FULL;
      cfg_q.clockwise     <= 1'b1;
      cfg_q.step_interval <= sps_pkg::INTERVAL_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sps_pkg::REG_STEP_MODE:     cfg_q.step_mode     <= pwdata[1:0];
        sps_pkg::REG_CLOCKWISE:     cfg_q.clockwise     <= pwdata[0];
        sps_pkg::REG_STEP_INTERVAL: cfg_q.step_interval <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sps_pkg::REG_STEP_MODE:     prdata = {30'd0, cfg_q.step_mode};
      sps_pkg::REG_CLOCKWISE:     prdata = {31'd0, cfg_q.clockwise};
      sps_pkg::REG_STEP_INTERVAL: prdata = {8'd0, cfg_q.step_interval};
      default:                    prdata = '0;
    endcase
  end

  // pipeline moves when the result register is empty or being drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_cmd_q <= command_i;
      s1_cnt_q <= step_count_i;
    end
  end

  // step logic and move state
  sps_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (s1_valid_q && advance),
    .command_i    (s1_cmd_q),
    .step_count_i (s1_cnt_q),
    .cfg_i        (cfg_q),
    .res_o        (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coil_a_o      = res_q.coils[0];
  assign coil_b_o      = res_q.coils[1];
  assign coil_c_o      = res_q.coils[2];
  assign coil_d_o      = res_q.coils[3];
  assign moving_o      = res_q.moving;
  assign step_strobe_o = res_q.step_strobe;

  `SPS_ASSERT_NOW(a_stall_needs_item, in_stall_o, s1_valid_q && out_valid_q)
  `SPS_ASSERT_NEXT(a_item_reaches_out, s1_valid_q && advance, out_valid_q)
  `SPS_ASSERT_NOW(a_strobe_while_moving, out_valid_o && step_strobe_o, moving_o)

endmodule

[bench/tb_stepper_phase_sequencer.sv]
`timescale 1ns / 100ps

module tb_stepper_phase_sequencer;

  // command code outside the decoded set, must leave the sequencer untouched
  localparam logic [1:0] CMD_NONE = 2'd3;

  // per-coil phase offsets, coil a in the lowest slot
  localparam logic [15:0] WAVE_OFS_CW  = {4'd1, 4'd3, 4'd2, 4'd0};
  localparam logic [15:0] WAVE_OFS_CCW = {4'd3, 4'd1, 4'd2, 4'd0};
  localparam logic [15:0] FULL_OFS_CW  = {4'd2, 4'd0, 4'd3, 4'd1};
  localparam logic [15:0] FULL_OFS_CCW = {4'd3, 4'd1, 4'd2, 4'd0};
  localparam logic [15:0] HALF_OFS     = {4'd6, 4'd2, 4'd4, 4'd0};
  localparam logic [19:0] MICRO_OFS    = {5'd24, 5'd8, 5'd16, 5'd0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = sps_pkg::CMD_TICK;
  logic [15:0] step_count_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        coil_a_o;
  logic        coil_b_o;
  logic        coil_c_o;
  logic        coil_d_o;
  logic        moving_o;
  logic        step_strobe_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // flow control knobs
  logic        idle_enable = 1'b1;
  logic        hold_off = 1'b0;
  int unsigned stall_run = 0;

  // predicted sequencer state and its register copy
  logic [1:0]  cfg_mode = sps_pkg::MODE_FULL;
  logic        cfg_cw = 1'b1;
  logic [23:0] cfg_interval = sps_pkg::INTERVAL_RESET;
  logic [4:0]  seq_phase = '0;
  logic [15:0] seq_steps_left = '0;
  logic [23:0] seq_ticks = '0;
  logic [9:0]  seq_pwm = '0;
  logic        seq_busy = 1'b0;
  logic [3:0]  seq_levels = '0;

  sps_pkg::res_t coil_results_q [$];
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned strobes_seen = 0;
  logic [3:0]  modes_seen = '0;

  stepper_phase_sequencer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .step_count_i  (step_count_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .coil_a_o      (coil_a_o),
    .coil_b_o      (coil_b_o),
    .coil_c_o      (coil_c_o),
    .coil_d_o      (coil_d_o),
    .moving_o      (moving_o),
    .step_strobe_o (step_strobe_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // micro-step duty, 0..1000
  function automatic int unsigned duty_at(input logic [4:0] idx);
    case (idx)
      5'd0, 5'd8:   duty_at = 500;
      5'd1, 5'd7:   duty_at = 625;
      5'd2, 5'd6:   duty_at = 750;
      5'd3, 5'd5:   duty_at = 875;
      5'd4:         duty_at = 1000;
      5'd9, 5'd31:  duty_at = 375;
      5'd10, 5'd30: duty_at = 250;
      5'd11, 5'd29: duty_at = 125;
      default:      duty_at = 0;
    endcase
  endfunction

  // apply the step pattern at the current phase; micro leaves the pins low
  function automatic void latch_step();
    logic [3:0] ofs;
    logic [4:0] pos;
    logic [3:0] lv;
    lv = '0;
    if (cfg_mode != sps_pkg::MODE_MICRO) begin
      for (int k = 0; k < 4; k++) begin
        if (cfg_mode == sps_pkg::MODE_WAVE) begin
          ofs = cfg_cw ? WAVE_OFS_CW[4*k +: 4] : WAVE_OFS_CCW[4*k +: 4];
        end else if (cfg_mode == sps_pkg::MODE_FULL) begin
          ofs = cfg_cw ? FULL_OFS_CW[4*k +: 4] : FULL_OFS_CCW[4*k +: 4];
        end else begin
          ofs = HALF_OFS[4*k +: 4];
        end
        pos = {1'b0, ofs} + seq_phase;
        if (cfg_mode == sps_pkg::MODE_WAVE) lv[k] = (pos[1:0] == 2'd0);
        else if (cfg_mode == sps_pkg::MODE_FULL) lv[k] = (pos[1:0] <= 2'd1);
        else lv[k] = (pos[2:0] <= 3'd2);
      end
    end
    seq_levels = lv;
  endfunction

  function automatic void end_move();
    seq_busy = 1'b0;
    seq_steps_left = '0;
    seq_ticks = '0;
    if (cfg_mode == sps_pkg::MODE_MICRO) seq_levels = '0;
  endfunction

  // one item through the predicted sequencer, returns the coil result
  function automatic sps_pkg::res_t advance_sequencer(input logic [1:0] cmd,
                                                      input logic [15:0] cnt);
    sps_pkg::res_t r;
    logic [23:0]   span;
    logic [3:0]    lv;
    logic          strobe;
    span = (cfg_interval == 24'd0) ? 24'd1 : cfg_interval;
    strobe = 1'b0;
    case (cmd)
      sps_pkg::CMD_START: begin
        seq_phase = '0;
        seq_ticks = '0;
        seq_pwm = '0;
        if (cnt == 16'd0) begin
          seq_busy = 1'b0;
          seq_steps_left = '0;
        end else begin
          seq_busy = 1'b1;
          seq_steps_left = cnt - 16'd1;
          latch_step();
          strobe = 1'b1;
        end
      end
      sps_pkg::CMD_STOP: begin
        if (seq_busy) end_move();
      end
      sps_pkg::CMD_TICK: begin
        if (seq_busy) begin
          seq_ticks = seq_ticks + 24'd1;
          if (seq_ticks >= span) begin
            seq_ticks = '0;
            if (seq_steps_left != 16'd0) begin
              seq_steps_left = seq_steps_left - 16'd1;
              if (cfg_mode >= sps_pkg::MODE_HALF && cfg_cw) seq_phase = seq_phase - 5'd1;
              else seq_phase = seq_phase + 5'd1;
              latch_step();
              strobe = 1'b1;
            end else begin
              end_move();
            end
          end
        end
      end
      default: ;
    endcase
    // all four pwm channels compare against the shared counter
    lv = seq_levels;
    if (seq_busy && cfg_mode == sps_pkg::MODE_MICRO) begin
      for (int k = 0; k < 4; k++) begin
        lv[k] = (seq_pwm < duty_at(5'(MICRO_OFS[5*k +: 5] + seq_phase)));
      end
    end
    if (cmd == sps_pkg::CMD_TICK) begin
      seq_pwm = (int'(seq_pwm) + 1 >= sps_pkg::PWM_PERIOD) ? 10'd0 : seq_pwm + 10'd1;
    end
    r.coils = lv;
    r.moving = seq_busy;
    r.step_strobe = strobe;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // one input transfer, with an occasional idle burst ahead of it
  task automatic send_item(input logic [1:0] cmd, input logic [15:0] cnt);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    step_count_i <= cnt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    coil_results_q.push_back(advance_sequencer(cmd, cnt));
    items_sent++;
  endtask

  // sender pauses until every predicted result has been seen
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (coil_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // apb write then read back
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
    logic [31:0] mask;
    logic [31:0] got;
    mask = (idx == sps_pkg::REG_STEP_MODE) ? 32'h3 :
           (idx == sps_pkg::REG_CLOCKWISE) ? 32'h1 : 32'hFF_FFFF;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {8'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      sps_pkg::REG_STEP_MODE: cfg_mode = value[1:0];
      sps_pkg::REG_CLOCKWISE: cfg_cw = value[0];
      default:                cfg_interval = value;
    endcase
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) != ({8'd0, value} & mask)) begin
      report_mismatch($sformatf("register %0d read %h, wrote %h", idx, got, value));
    end
    @(posedge clk_i);
  endtask

  task automatic write_config(input logic [1:0] mode, input logic cw, input logic [23:0] span);
    wait_drained();
    write_reg(sps_pkg::REG_STEP_MODE, 24'(mode));
    write_reg(sps_pkg::REG_CLOCKWISE, 24'(cw));
    write_reg(sps_pkg::REG_STEP_INTERVAL, span);
    modes_seen[mode] = 1'b1;
  endtask

  task automatic hold_receiver(input int unsigned cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_off <= 1'b0;
  endtask

  // register defaults out of reset: full step, clockwise, long interval
  task automatic test_reset_defaults();
    modes_seen[sps_pkg::MODE_FULL] = 1'b1;
    send_item(sps_pkg::CMD_START, 16'd3);
    repeat (3) send_item(sps_pkg::CMD_TICK, 16'hFFFF);
    send_item(CMD_NONE, 16'd7);
    send_item(sps_pkg::CMD_STOP, 16'd0);
  endtask

  // idle commands, empty start, restart, stop mid-move, zero interval
  task automatic test_directed();
    write_config(sps_pkg::MODE_HALF, 1'b1, 24'd0);
    send_item(sps_pkg::CMD_TICK, 16'd0);
    send_item(sps_pkg::CMD_STOP, 16'd0);
    send_item(CMD_NONE, 16'hFFFF);
    send_item(sps_pkg::CMD_START, 16'd0);
    send_item(sps_pkg::CMD_START, 16'd2);
    repeat (4) send_item(sps_pkg::CMD_TICK, 16'd0);
    send_item(sps_pkg::CMD_START, 16'hFFFF);
    send_item(sps_pkg::CMD_TICK, 16'd0);
    send_item(CMD_NONE, 16'd0);
    send_item(sps_pkg::CMD_TICK, 16'd0);
    send_item(sps_pkg::CMD_START, 16'd1);
    send_item(sps_pkg::CMD_STOP, 16'd0);
    send_item(sps_pkg::CMD_TICK, 16'd0);
    send_item(sps_pkg::CMD_STOP, 16'd0);
  endtask

  // random settings per phase, mostly complete moves with random content
  task automatic test_random_moves();
    int unsigned phase_no;
    int unsigned pick;
    int unsigned ticks;
    longint      need;
    logic [1:0]  mode;
    logic        cw;
    logic [23:0] span;
    logic [15:0] steps;
    phase_no = 0;
    while (items_sent < 420) begin
      mode = (phase_no < 8) ? 2'(phase_no % 4) : 2'($urandom_range(0, 3));
      cw = (phase_no < 8) ? 1'(phase_no / 4) : 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 15);
      if (pick == 0) span = 24'd0;
      else if (pick == 1 || phase_no == 3) span = 24'hFF_FFFF;
      else if (pick < 12) span = 24'($urandom_range(1, 4));
      else span = 24'($urandom_range(5, 24));
      write_config(mode, cw, span);
      idle_enable <= ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 5)) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          send_item(2'($urandom_range(0, 3)), 16'($urandom));
        end else begin
          steps = (pick == 1) ? 16'($urandom) : 16'($urandom_range(1, 6));
          send_item(sps_pkg::CMD_START, steps);
          need = longint'(steps) * ((span == 24'd0) ? 1 : longint'(span)) + 1;
          ticks = (need > 48) ? 48 : int'(need) + $urandom_range(0, 3);
          if (pick == 2) ticks = ticks / 2;
          repeat (ticks) send_item(sps_pkg::CMD_TICK, 16'($urandom));
          if (pick == 2) send_item(sps_pkg::CMD_STOP, 16'($urandom));
        end
      end
      phase_no++;
    end
  endtask

  // micro stepping over a long run of ticks, move ends on its own
  task automatic test_micro_pwm();
    write_config(sps_pkg::MODE_MICRO, 1'b1, 24'd30);
    idle_enable <= 1'b1;
    send_item(sps_pkg::CMD_START, 16'd12);
    repeat (400) send_item(sps_pkg::CMD_TICK, 16'($urandom));
    send_item(sps_pkg::CMD_STOP, 16'd0);
  endtask

  // receiver held off long enough for the block to back up its input
  task automatic test_backpressure();
    write_config(sps_pkg::MODE_WAVE, 1'b0, 24'd2);
    idle_enable <= 1'b0;
    fork
      hold_receiver(200);
    join_none
    send_item(sps_pkg::CMD_START, 16'd10);
    repeat (30) send_item(sps_pkg::CMD_TICK, 16'd0);
    send_item(sps_pkg::CMD_STOP, 16'd0);
    wait_drained();
    idle_enable <= 1'b1;
  endtask

  // closing stretch at full rate, no idling on either side
  task automatic test_full_rate();
    write_config(sps_pkg::MODE_HALF, 1'b0, 24'd3);
    idle_enable <= 1'b0;
    send_item(sps_pkg::CMD_START, 16'd25);
    repeat (90) send_item(sps_pkg::CMD_TICK, 16'($urandom));
    send_item(sps_pkg::CMD_START, 16'd0);
    send_item(sps_pkg::CMD_STOP, 16'd0);
    send_item(sps_pkg::CMD_START, 16'd4);
    repeat (20) send_item(sps_pkg::CMD_TICK, 16'd0);
  endtask

  // receiver stall bursts, or a long hold when asked
  always @(posedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
    end else if (!idle_enable) begin
      out_stall_i <= 1'b0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      stall_run <= $urandom_range(1, 14);
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  // compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin : result_check
    sps_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (coil_results_q.size() == 0) begin
        report_mismatch("output transfer with no result outstanding");
      end else begin
        want = coil_results_q.pop_front();
        if (coil_a_o !== want.coils[0])
          report_mismatch($sformatf("result %0d coil_a %b want %b",
                                    results_checked, coil_a_o, want.coils[0]));
        if (coil_b_o !== want.coils[1])
          report_mismatch($sformatf("result %0d coil_b %b want %b",
                                    results_checked, coil_b_o, want.coils[1]));
        if (coil_c_o !== want.coils[2])
          report_mismatch($sformatf("result %0d coil_c %b want %b",
                                    results_checked, coil_c_o, want.coils[2]));
        if (coil_d_o !== want.coils[3])
          report_mismatch($sformatf("result %0d coil_d %b want %b",
                                    results_checked, coil_d_o, want.coils[3]));
        if (moving_o !== want.moving)
          report_mismatch($sformatf("result %0d moving %b want %b",
                                    results_checked, moving_o, want.moving));
        if (step_strobe_o !== want.step_strobe)
          report_mismatch($sformatf("result %0d step_strobe %b want %b",
                                    results_checked, step_strobe_o, want.step_strobe));
        if (want.step_strobe) strobes_seen++;
        results_checked++;
      end
    end
  end

  // test sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random_moves();
    test_micro_pwm();
    test_backpressure();
    test_full_rate();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (coil_results_q.size() != 0) report_mismatch("results still outstanding at the end");
    $display("covered %0d input transfers, %0d results checked, %0d step strobes",
             items_sent, results_checked, strobes_seen);
    $display("step modes exercised %b (wave in bit 0), both directions, intervals 0 to max",
             modes_seen);
    if (error_count == 0) begin
      $display("tb_stepper_phase_sequencer: clean");
    end else begin
      $display("tb_stepper_phase_sequencer: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", coil_results_q.size());
    $display("tb_stepper_phase_sequencer: errors");
    $finish;
  end

endmodule
